### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files. Both macros clock on i_clk and
// are disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("invariant check failed");

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/enmo_am_pkg.sv
package enmo_am_pkg;

    // Field widths.
    localparam int AXIS_W   = 16;
    localparam int FSC_W    = 2;
    localparam int ENMO_W   = 19;
    localparam int CNT_W    = 13;
    localparam int CFG_W    = 19;
    localparam int CFG_IDX_W = 2;

    // Square and root datapath.
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 16;
    localparam int ROOT_STEPS = 16;
    localparam int STEP_W     = $clog2(ROOT_STEPS);
    localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 2);
    localparam logic [ENMO_W-1:0] ONE_G = ENMO_W'(16384);

    // Averaging and ring.
    localparam int AVG_LEN        = 32;
    localparam int AVG_W          = $clog2(AVG_LEN);
    localparam int SUM_W          = ENMO_W + AVG_W;
    localparam int WINDOW         = 600;
    localparam int RING_AW        = $clog2(WINDOW);
    localparam int FILL_W         = $clog2(WINDOW + 1);
    localparam int SUMMARY_PERIOD = 2;

    // Register reset values.
    localparam logic [FSC_W-1:0]  FSC_RESET   = FSC_W'(1);
    localparam logic [ENMO_W-1:0] LEVEL_RESET = ENMO_W'(1648);
    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(240);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_SCALE     = 2'd0,
        CFG_ACTIVITY_LEVEL = 2'd1,
        CFG_COUNT_LIMIT    = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQUARE,
        MAG_ROOT,
        MAG_FINISH
    } t_mag_state;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_MAG,
        TOP_SWEEP,
        TOP_DRAIN,
        TOP_RESULT
    } t_top_state;

    typedef struct packed {
        logic square;
        logic root_step;
        logic finish;
    } t_mag_ctrl;

    typedef struct packed {
        logic in_stall;
        logic mag_start;
        logic take_sample;
        logic sweep;
        logic result;
    } t_top_ctrl;

endpackage

### rtl/enmo_am_ram.sv
module enmo_am_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 600
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/enmo_am_mag.sv
`include "assert_macros.svh"

module enmo_am_mag (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [enmo_am_pkg::AXIS_W-1:0] i_accel_x,
    input  logic signed [enmo_am_pkg::AXIS_W-1:0] i_accel_y,
    input  logic signed [enmo_am_pkg::AXIS_W-1:0] i_accel_z,
    input  logic [enmo_am_pkg::FSC_W-1:0]       i_fsc,
    output logic                                o_done,
    output logic [enmo_am_pkg::ENMO_W-1:0]      o_enmo
);
    import enmo_am_pkg::*;

    t_mag_state r_state, n_state;
    t_mag_ctrl  ctrl;

    logic [STEP_W-1:0]           r_cnt;
    logic signed [AXIS_W-1:0]    r_ax [3];
    logic [SQ_W-1:0]             r_prod;
    logic [SQ_W-1:0]             r_rem;
    logic [SQ_W-1:0]             r_root;
    logic [SQ_W-1:0]             r_bit;
    logic                        r_done;
    logic [ENMO_W-1:0]           r_enmo;

    logic signed [AXIS_W-1:0]    axis;
    logic [AXIS_W-1:0]           axis_abs;
    logic [SQ_W-1:0]             trial;
    logic                        fits;
    logic [ENMO_W-1:0]           mag;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            MAG_IDLE:   if (i_start) n_state = MAG_SQUARE;
            MAG_SQUARE: if (r_cnt == STEP_W'(3)) n_state = MAG_ROOT;
            MAG_ROOT:   if (r_cnt == STEP_W'(ROOT_STEPS - 1)) n_state = MAG_FINISH;
            MAG_FINISH: n_state = MAG_IDLE;
            default:    n_state = MAG_IDLE;
        endcase
    end

    // Datapath controls.
    always_comb begin
        ctrl = '0;
        case (r_state)
            MAG_SQUARE: ctrl.square    = 1'b1;
            MAG_ROOT:   ctrl.root_step = 1'b1;
            MAG_FINISH: ctrl.finish    = 1'b1;
            default:    ctrl = '0;
        endcase
    end

    // One axis squared per cycle through a single multiplier.
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    axis = r_ax[0];
            2'd1:    axis = r_ax[1];
            default: axis = r_ax[2];
        endcase
        axis_abs = axis[AXIS_W-1] ? AXIS_W'(-axis) : AXIS_W'(axis);
    end

    // Bit-pair square root step.
    assign trial = r_root + r_bit;
    assign fits  = (r_rem >= trial);
    assign mag   = ENMO_W'(r_root[ROOT_W-1:0]) << i_fsc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MAG_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ctrl.finish;
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == MAG_IDLE && i_start) begin
            r_ax[0] <= i_accel_x;
            r_ax[1] <= i_accel_y;
            r_ax[2] <= i_accel_z;
        end
        if (ctrl.square) begin
            r_prod <= SQ_W'(axis_abs) * SQ_W'(axis_abs);
            if (r_cnt == '0) begin
                r_rem <= '0;
            end else begin
                r_rem <= r_rem + r_prod;
            end
            r_root <= '0;
            r_bit  <= ROOT_BIT_INIT;
        end
        if (ctrl.root_step) begin
            if (fits) begin
                r_rem  <= r_rem - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (ctrl.finish) begin
            r_enmo <= (mag > ONE_G) ? (mag - ONE_G) : '0;
        end
    end

    assign o_done = r_done;
    assign o_enmo = r_enmo;

    `ASSERT_NEXT(a_done_single, r_done, !r_done)
    `ASSERT_ALWAYS(a_bit_onehot, (r_state == MAG_ROOT) |-> $onehot(r_bit))

endmodule

### rtl/enmo_activity_monitor.sv
// ENMO activity monitor. Each accepted beat carries one raw signed 3-axis
// accelerometer sample; its ENMO value (square root of the sum of squares,
// shifted left by the full-scale code, minus one g of 16384 counts and
// clamped at zero) is formed by one multiplier and 32-bit add and compare
// logic under a small sequencer: squaring and accumulating the three axes,
// sixteen root steps and a finishing step, so the input is stalled while
// each sample is processed. Every 32nd sample closes a second: the mean is
// written into a 600-entry ring memory and the ring is then swept one entry
// per cycle through its registered read port to count the entries above
// activity_level; the sweep covers the entries written so far (at most
// 600) and is followed by a drain state, in which the last read lands,
// and a result state. No clearing pass is needed after reset: a fill
// count marks which ring entries hold data. One result beat follows each
// closed second; it waits in an output register, so the next sample is
// taken while the previous result is still stalled, and only a second
// result finding that register occupied holds the block.
`include "assert_macros.svh"

module enmo_activity_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [enmo_am_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [enmo_am_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [enmo_am_pkg::AXIS_W-1:0] i_accel_x,
    input  logic signed [enmo_am_pkg::AXIS_W-1:0] i_accel_y,
    input  logic signed [enmo_am_pkg::AXIS_W-1:0] i_accel_z,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [enmo_am_pkg::ENMO_W-1:0]        o_second_enmo,
    output logic                                  o_summary_valid,
    output logic [enmo_am_pkg::ENMO_W-1:0]        o_summary_enmo,
    output logic [enmo_am_pkg::CNT_W-1:0]         o_active_count,
    output logic                                  o_trigger
);
    import enmo_am_pkg::*;

    // Configuration registers.
    logic [FSC_W-1:0]  r_fsc;
    logic [ENMO_W-1:0] r_level;
    logic [CNT_W-1:0]  r_limit;

    // Sequencer.
    t_top_state r_state, n_state;
    t_top_ctrl  ctrl;

    // Per-second accumulation.
    logic [SUM_W-1:0]   r_sum;
    logic [AVG_W-1:0]   r_count;
    logic [SUM_W-1:0]   sum_next;
    logic [ENMO_W-1:0]  mean;
    logic               last_sample;

    // Ring bookkeeping.
    logic [RING_AW-1:0] r_wr_idx;
    logic [RING_AW-1:0] wr_idx_next;
    logic [FILL_W-1:0]  r_fill;
    logic [RING_AW-1:0] r_addr;
    logic               r_pend;
    logic [ENMO_W-1:0]  rd_data;
    logic               ring_we;
    logic               sweep_last;

    // Second results held until the result cycle.
    logic [ENMO_W-1:0]  r_prev;
    logic [ENMO_W-1:0]  r_mean;
    logic               r_sum_ok;
    logic [ENMO_W-1:0]  r_summary;
    logic [CNT_W-1:0]   r_act;
    logic [CNT_W-1:0]   r_refr;
    logic               sum_ok;
    logic [ENMO_W:0]    pair_sum;
    logic               trig;
    logic               load_out;

    // Output register.
    logic               r_out_valid;
    logic [ENMO_W-1:0]  r_out_second;
    logic               r_out_sum_valid;
    logic [ENMO_W-1:0]  r_out_summary;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_trigger;

    // Magnitude unit.
    logic               mag_done;
    logic [ENMO_W-1:0]  mag_enmo;

    enmo_am_mag u_mag (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ctrl.mag_start),
        .i_accel_x (i_accel_x),
        .i_accel_y (i_accel_y),
        .i_accel_z (i_accel_z),
        .i_fsc     (r_fsc),
        .o_done    (mag_done),
        .o_enmo    (mag_enmo)
    );

    enmo_am_ram #(
        .WIDTH (ENMO_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wr_idx),
        .i_wdata (mean),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    // Configuration writes. Indexes past the register list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsc   <= FSC_RESET;
            r_level <= LEVEL_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FULL_SCALE:     r_fsc   <= i_cfg_data[FSC_W-1:0];
                CFG_ACTIVITY_LEVEL: r_level <= i_cfg_data[ENMO_W-1:0];
                CFG_COUNT_LIMIT:    r_limit <= i_cfg_data[CNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // The sample that completes a second; its mean is the truncated average.
    assign last_sample = (r_count == AVG_W'(AVG_LEN - 1));
    assign sum_next    = r_sum + SUM_W'(mag_enmo);
    assign mean        = ENMO_W'(sum_next >> AVG_W);

    // Write index after this second's write, and the two-second summary,
    // which is skipped on the write that wraps the ring.
    assign wr_idx_next = (r_wr_idx == RING_AW'(WINDOW - 1)) ? '0 : r_wr_idx + RING_AW'(1);
    assign sum_ok      = ((wr_idx_next % SUMMARY_PERIOD) == 0)
                      && (wr_idx_next >= RING_AW'(SUMMARY_PERIOD));
    assign pair_sum    = {1'b0, r_prev} + {1'b0, mean};

    // The sweep reads entries from zero up to the fill count less one, which covers every entry written so far.
    assign sweep_last = (FILL_W'(r_addr) == r_fill - FILL_W'(1));

    // The refractory counter must have reached the window length before a
    // count above the limit can fire.
    assign trig     = (r_refr >= CNT_W'(WINDOW)) && (r_act > r_limit);
    assign load_out = ctrl.result && (!r_out_valid || !i_out_stall);
    assign ring_we  = ctrl.take_sample && last_sample;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            TOP_IDLE:   if (i_in_valid) n_state = TOP_MAG;
            TOP_MAG: begin
                if (mag_done) begin
                    n_state = last_sample ? TOP_SWEEP : TOP_IDLE;
                end
            end
            TOP_SWEEP:  if (sweep_last) n_state = TOP_DRAIN;
            TOP_DRAIN:  n_state = TOP_RESULT;
            TOP_RESULT: if (!r_out_valid || !i_out_stall) n_state = TOP_IDLE;
            default:    n_state = TOP_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        ctrl          = '0;
        ctrl.in_stall = 1'b1;
        case (r_state)
            TOP_IDLE: begin
                ctrl.in_stall  = 1'b0;
                ctrl.mag_start = i_in_valid;
            end
            TOP_MAG:    ctrl.take_sample = mag_done;
            TOP_SWEEP:  ctrl.sweep       = 1'b1;
            TOP_RESULT: ctrl.result      = 1'b1;
            default:    ctrl.in_stall    = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= TOP_IDLE;
            r_sum       <= '0;
            r_count     <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_prev      <= '0;
            r_act       <= '0;
            r_refr      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= ctrl.sweep;

            if (ctrl.take_sample) begin
                if (last_sample) begin
                    r_sum    <= '0;
                    r_count  <= '0;
                    r_wr_idx <= wr_idx_next;
                    if (r_fill != FILL_W'(WINDOW)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_prev <= mean;
                    r_act  <= '0;
                end else begin
                    r_sum   <= sum_next;
                    r_count <= r_count + AVG_W'(1);
                end
            end

            // Read data arrives in the cycle after its address.
            if (r_pend && (rd_data > r_level)) begin
                r_act <= r_act + CNT_W'(1);
            end

            if (load_out) begin
                if (trig) begin
                    r_refr <= '0;
                end else if (r_refr < CNT_W'(WINDOW)) begin
                    r_refr <= r_refr + CNT_W'(1);
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_mean    <= mean;
            r_sum_ok  <= sum_ok;
            r_summary <= sum_ok ? pair_sum[ENMO_W:1] : '0;
        end
        if (ring_we) begin
            r_addr <= '0;
        end else if (ctrl.sweep) begin
            r_addr <= r_addr + RING_AW'(1);
        end
        if (load_out) begin
            r_out_second    <= r_mean;
            r_out_sum_valid <= r_sum_ok;
            r_out_summary   <= r_summary;
            r_out_count     <= r_act;
            r_out_trigger   <= trig;
        end
    end

    assign o_in_stall      = ctrl.in_stall;
    assign o_out_valid     = r_out_valid;
    assign o_second_enmo   = r_out_second;
    assign o_summary_valid = r_out_sum_valid;
    assign o_summary_enmo  = r_out_summary;
    assign o_active_count  = r_out_count;
    assign o_trigger       = r_out_trigger;

    `ASSERT_ALWAYS(a_done_in_mag, mag_done |-> (r_state == TOP_MAG))
    `ASSERT_ALWAYS(a_fill_tracks_index, (r_fill < FILL_W'(WINDOW)) |-> (r_fill == FILL_W'(r_wr_idx)))
    `ASSERT_NEXT(a_trigger_clears, load_out && trig, r_refr == '0)

endmodule

### tb/sv/enmo_activity_monitor_test.sv
`timescale 1ns / 100ps

module enmo_activity_monitor_test;
    import enmo_am_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam longint      TIMEOUT_NS    = 100_000_000;
    localparam int          DIR_ROWS      = 11;
    localparam int unsigned RANDOM_ITEMS  = 800;
    localparam int unsigned QUIET_CYCLES  = 100;
    localparam int unsigned END_WAIT      = 700;
    localparam int          MAX_REPORTS   = 10;
    localparam logic [CNT_W-1:0] LIMIT_NEVER = CNT_W'(4096);

    // One closed second as the block reports it.
    typedef struct packed {
        logic [ENMO_W-1:0] mean;
        logic              summary_valid;
        logic [ENMO_W-1:0] summary;
        logic [CNT_W-1:0]  active;
        logic              trigger;
    } t_second_rec;

    typedef struct packed {
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } t_axes;

    // A directed row is one whole second of a repeated sample under one setting.
    // Where known is set, the result is typed in by hand instead of predicted.
    typedef struct packed {
        logic [FSC_W-1:0]  fsc;
        logic [ENMO_W-1:0] level;
        logic [CNT_W-1:0]  limit;
        t_axes             smp;
        logic              known;
        t_second_rec       res;
    } t_dir_row;

    typedef enum logic [1:0] {
        MOTION_QUIET,
        MOTION_ACTIVE,
        MOTION_NOISE
    } t_motion;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    t_cfg_index        cfg_idx   = CFG_FULL_SCALE;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic signed [AXIS_W-1:0] in_x = '0;
    logic signed [AXIS_W-1:0] in_y = '0;
    logic signed [AXIS_W-1:0] in_z = '0;
    logic              out_stall = 1'b0;

    logic              o_in_stall;
    logic              o_out_valid;
    logic [ENMO_W-1:0] o_second_enmo;
    logic              o_summary_valid;
    logic [ENMO_W-1:0] o_summary_enmo;
    logic [CNT_W-1:0]  o_active_count;
    logic              o_trigger;

    enmo_activity_monitor dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_accel_x       (in_x),
        .i_accel_y       (in_y),
        .i_accel_z       (in_z),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_second_enmo   (o_second_enmo),
        .o_summary_valid (o_summary_valid),
        .o_summary_enmo  (o_summary_enmo),
        .o_active_count  (o_active_count),
        .o_trigger       (o_trigger)
    );

    always #HALF_PERIOD clk = ~clk;

    // The predictor keeps its own copy of the settings and of the block state.
    // Bit types start at zero, which matches the state right after reset.
    logic [FSC_W-1:0]  cfg_fsc   = FSC_RESET;
    logic [ENMO_W-1:0] cfg_level = LEVEL_RESET;
    logic [CNT_W-1:0]  cfg_limit = LIMIT_RESET;

    int unsigned       acc_sum;
    int unsigned       acc_n;
    bit [ENMO_W-1:0]   sec_ring [WINDOW];
    int unsigned       ring_wr;
    bit [ENMO_W-1:0]   prev_second;
    int unsigned       model_refract;

    // Closed seconds that the block still owes, oldest first.
    t_second_rec       seconds_due [$];
    bit                known_armed;
    t_second_rec       known_rec;

    int unsigned       items_sent;
    int unsigned       burst_left;
    int unsigned       fail_count;

    function automatic int unsigned axis_square(input logic signed [AXIS_W-1:0] a);
        int v;
        v = a;
        if (v < 0)
            v = -v;
        return v * v;
    endfunction

    // Digit-by-digit integer square root, two bits of the radicand per step.
    function automatic logic [ROOT_W-1:0] int_sqrt(input logic [SQ_W-1:0] v);
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] b;
        rem  = v;
        root = '0;
        b    = ROOT_BIT_INIT;
        while (b > rem)
            b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root[ROOT_W-1:0];
    endfunction

    // Takes one accepted sample into the model; returns 1 when it closes a second.
    function automatic bit predict_sample(input t_axes s, output t_second_rec rec);
        logic [SQ_W-1:0]   sq;
        logic [ENMO_W-1:0] mag;
        logic [ENMO_W-1:0] enmo;
        logic [ENMO_W-1:0] mean;
        int unsigned       count;
        rec  = '0;
        sq   = axis_square(s.x) + axis_square(s.y) + axis_square(s.z);
        mag  = ENMO_W'(int_sqrt(sq)) << cfg_fsc;
        enmo = (mag > ONE_G) ? mag - ONE_G : '0;
        acc_sum += enmo;
        acc_n++;
        if (acc_n < AVG_LEN)
            return 1'b0;

        mean    = ENMO_W'(acc_sum / AVG_LEN);
        acc_sum = 0;
        acc_n   = 0;
        sec_ring[ring_wr] = mean;
        ring_wr = (ring_wr + 1 >= WINDOW) ? 0 : ring_wr + 1;

        // The whole ring is recounted each second against the current level.
        count = 0;
        for (int i = 0; i < WINDOW; i++)
            if (sec_ring[i] > cfg_level)
                count++;

        // Once the refractory counter sits at the window length it holds there
        // until a count above the limit fires the trigger.
        if (model_refract >= WINDOW) begin
            if (count > cfg_limit) begin
                rec.trigger   = 1'b1;
                model_refract = 0;
            end
        end else begin
            model_refract++;
        end

        // The write that wraps the ring back to entry zero gives no summary.
        if ((ring_wr % SUMMARY_PERIOD) == 0 && ring_wr >= SUMMARY_PERIOD) begin
            rec.summary_valid = 1'b1;
            rec.summary = ENMO_W'(({1'b0, prev_second} + {1'b0, mean}) >> 1);
        end
        prev_second = mean;
        rec.mean    = mean;
        rec.active  = CNT_W'(count);
        return 1'b1;
    endfunction

    function automatic logic signed [AXIS_W-1:0] clip16(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return AXIS_W'(v);
    endfunction

    function automatic int spread(input int a);
        return int'($urandom_range(0, 2 * a)) - a;
    endfunction

    // Samples are scaled to the current range so that one g is one g whatever
    // the full-scale code. Quiet seconds stay near rest, active ones swing
    // several g, and noise covers the whole input range.
    function automatic t_axes make_sample(input t_motion kind);
        int    g;
        int    nz;
        t_axes s;
        g = 16384 >> cfg_fsc;
        case (kind)
            MOTION_QUIET: begin
                nz = g + spread(g / 64);
                if ($urandom_range(0, 1) == 1)
                    nz = -nz;
                s.x = clip16(spread(g / 64));
                s.y = clip16(spread(g / 64));
                s.z = clip16(nz);
            end
            MOTION_ACTIVE: begin
                s.x = clip16(spread(2 * g));
                s.y = clip16(spread(2 * g));
                s.z = clip16(g + spread(3 * g));
            end
            default: begin
                s.x = AXIS_W'($urandom);
                s.y = AXIS_W'($urandom);
                s.z = AXIS_W'($urandom);
            end
        endcase
        return s;
    endfunction

    function automatic t_dir_row dir_row(
        input logic [FSC_W-1:0]  fsc,
        input logic [ENMO_W-1:0] level,
        input logic [CNT_W-1:0]  limit,
        input int                x,
        input int                y,
        input int                z,
        input logic              known,
        input int                mean,
        input int                sv,
        input int                summary,
        input int                active
    );
        t_dir_row r;
        r.fsc   = fsc;
        r.level = level;
        r.limit = limit;
        r.smp.x = AXIS_W'(x);
        r.smp.y = AXIS_W'(y);
        r.smp.z = AXIS_W'(z);
        r.known = known;
        r.res.mean          = ENMO_W'(mean);
        r.res.summary_valid = sv[0];
        r.res.summary       = ENMO_W'(summary);
        r.res.active        = CNT_W'(active);
        r.res.trigger       = 1'b0;
        return r;
    endfunction

    // Presents one sample beat and holds it until the block accepts it. The
    // sender runs in bursts; after a burst it may drop valid for a while.
    task automatic send_sample(input t_axes s);
        t_second_rec rec;
        int unsigned gap;
        in_valid <= 1'b1;
        in_x     <= s.x;
        in_y     <= s.y;
        in_z     <= s.z;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        items_sent++;
        if (predict_sample(s, rec)) begin
            if (known_armed) begin
                rec         = known_rec;
                known_armed = 1'b0;
            end
            seconds_due.push_back(rec);
        end
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_second(input t_motion kind);
        repeat (AVG_LEN) send_sample(make_sample(kind));
    endtask

    // The sender stops until every owed second has come out, then leaves the
    // block time to finish a sample that closes no second.
    task automatic settle(input int unsigned quiet);
        in_valid <= 1'b0;
        while (seconds_due.size() != 0)
            @(posedge clk);
        repeat (quiet) @(posedge clk);
    endtask

    // All three registers are written on back-to-back edges while idle.
    task automatic apply_config(
        input logic [FSC_W-1:0]  fsc,
        input logic [ENMO_W-1:0] level,
        input logic [CNT_W-1:0]  limit
    );
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FULL_SCALE;
        cfg_data <= CFG_W'(fsc);
        @(posedge clk);
        cfg_idx  <= CFG_ACTIVITY_LEVEL;
        cfg_data <= CFG_W'(level);
        @(posedge clk);
        cfg_idx  <= CFG_COUNT_LIMIT;
        cfg_data <= CFG_W'(limit);
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_fsc   = fsc;
        cfg_level = level;
        cfg_limit = limit;
    endtask

    task automatic report_mismatch(
        input string       what,
        input t_second_rec want,
        input t_second_rec got
    );
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s at %0t:", what, $realtime);
            $display("  expected mean=%0d sv=%0d summary=%0d active=%0d trig=%0d",
                     want.mean, want.summary_valid, want.summary,
                     want.active, want.trigger);
            $display("  got      mean=%0d sv=%0d summary=%0d active=%0d trig=%0d",
                     got.mean, got.summary_valid, got.summary,
                     got.active, got.trigger);
        end
    endtask

    // The result side stalls in stretches of its own. Free stretches are
    // sometimes long, and very rarely a stall lasts longer than a whole second
    // so that a second result finds the output register still occupied.
    int unsigned rx_left     = 0;
    bit          rx_stalling = 1'b0;

    always @(posedge clk) begin
        if (rx_left != 0) begin
            rx_left--;
        end else begin
            rx_stalling = !rx_stalling;
            if (rx_stalling)
                rx_left = ($urandom_range(0, 255) == 0) ? $urandom_range(1500, 3000)
                                                        : $urandom_range(1, 50);
            else
                rx_left = ($urandom_range(0, 7) == 0) ? 500 : $urandom_range(0, 80);
        end
        out_stall <= rx_stalling;
    end

    // Every result beat taken by the receiver is compared with the oldest
    // owed second, field by field.
    always @(posedge clk) begin : result_check
        t_second_rec got;
        t_second_rec want;
        if (rst_n && o_out_valid && !out_stall) begin
            got.mean          = o_second_enmo;
            got.summary_valid = o_summary_valid;
            got.summary       = o_summary_enmo;
            got.active        = o_active_count;
            got.trigger       = o_trigger;
            if (seconds_due.size() == 0) begin
                report_mismatch("unexpected result", '0, got);
            end else begin
                want = seconds_due.pop_front();
                if (got.mean !== want.mean || got.summary_valid !== want.summary_valid
                        || got.summary !== want.summary || got.active !== want.active
                        || got.trigger !== want.trigger)
                    report_mismatch("result mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_dir_row    rows [DIR_ROWS];
        t_motion     kind;
        int unsigned start_items;
        int unsigned r;
        logic [FSC_W-1:0]  fsc_pick;
        logic [ENMO_W-1:0] level_pick;
        logic [CNT_W-1:0]  limit_pick;

        // Rows typed in by hand: the cleared ring after reset, exactly two g at
        // the 4 g range, exactly one g at the 2 g range (clamped to zero), and
        // the largest possible magnitude at the 16 g range. The rest cover the
        // opposite extremes of the axes and the registers and are predicted.
        rows[0]  = dir_row(2'd1, LEVEL_RESET, LIMIT_RESET, 0, 0, 0,
                           1'b1, 0, 0, 0, 0);
        rows[1]  = dir_row(2'd1, LEVEL_RESET, LIMIT_RESET, 16384, 0, 0,
                           1'b1, 16384, 1, 8192, 1);
        rows[2]  = dir_row(2'd0, LEVEL_RESET, LIMIT_RESET, 16384, 0, 0,
                           1'b1, 0, 0, 0, 1);
        rows[3]  = dir_row(2'd3, LEVEL_RESET, LIMIT_RESET, -32768, -32768, -32768,
                           1'b1, 437656, 1, 218828, 2);
        rows[4]  = dir_row(2'd2, LEVEL_RESET, LIMIT_RESET, 32767, 32767, 32767,
                           1'b0, 0, 0, 0, 0);
        rows[5]  = dir_row(2'd3, LEVEL_RESET, LIMIT_RESET, -32768, 0, 0,
                           1'b0, 0, 0, 0, 0);
        rows[6]  = dir_row(2'd3, '0, '0, -1, 1, -1,
                           1'b0, 0, 0, 0, 0);
        rows[7]  = dir_row(2'd0, ENMO_W'(524287), LIMIT_NEVER, 32767, -32768, 12345,
                           1'b0, 0, 0, 0, 0);
        rows[8]  = dir_row(2'd1, LEVEL_RESET, LIMIT_RESET, 8192, 0, 0,
                           1'b0, 0, 0, 0, 0);
        rows[9]  = dir_row(2'd1, LEVEL_RESET, LIMIT_RESET, 0, -8193, 0,
                           1'b0, 0, 0, 0, 0);
        rows[10] = dir_row(2'd2, ENMO_W'(1000), CNT_W'(100), 5000, -6000, 7000,
                           1'b0, 0, 0, 0, 0);
        kind = MOTION_QUIET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed seconds. A row that needs another setting first waits for
        // the block to go idle.
        for (int i = 0; i < DIR_ROWS; i++) begin
            if (rows[i].fsc != cfg_fsc || rows[i].level != cfg_level
                    || rows[i].limit != cfg_limit) begin
                settle(QUIET_CYCLES);
                apply_config(rows[i].fsc, rows[i].level, rows[i].limit);
            end
            known_armed = rows[i].known;
            known_rec   = rows[i].res;
            repeat (AVG_LEN) send_sample(rows[i].smp);
        end

        // Random phases under random settings. Phases end at arbitrary sample
        // counts, so some settings change in the middle of a second.
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            settle(QUIET_CYCLES);
            fsc_pick = FSC_W'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       level_pick = '0;
                1:       level_pick = ENMO_W'(524287);
                2:       level_pick = LEVEL_RESET;
                default: level_pick = ENMO_W'($urandom_range(0, 40000));
            endcase
            case ($urandom_range(0, 3))
                0:       limit_pick = '0;
                1:       limit_pick = LIMIT_NEVER;
                2:       limit_pick = CNT_W'($urandom_range(0, 10));
                default: limit_pick = CNT_W'($urandom_range(0, 4096));
            endcase
            apply_config(fsc_pick, level_pick, limit_pick);
            repeat ($urandom_range(16, 200)) begin
                if (acc_n == 0) begin
                    r = $urandom_range(0, 9);
                    kind = (r < 4) ? MOTION_ACTIVE : (r < 8) ? MOTION_QUIET : MOTION_NOISE;
                end
                send_sample(make_sample(kind));
            end
        end

        // Close the open second, then a few closing seconds at the opposite
        // register extremes.
        while (acc_n != 0)
            send_sample(make_sample(MOTION_QUIET));
        settle(QUIET_CYCLES);
        apply_config(2'd3, '0, '0);
        repeat (2) send_second(MOTION_NOISE);
        repeat (2) send_second(MOTION_ACTIVE);

        settle(END_WAIT);
        if (fail_count == 0 && seconds_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### enmo_activity_monitor.f
+incdir+rtl
rtl/enmo_am_pkg.sv
rtl/enmo_am_ram.sv
rtl/enmo_am_mag.sv
rtl/enmo_activity_monitor.sv
tb/sv/enmo_activity_monitor_test.sv
